/* rtl/gmpsk_pkg.sv */
// shared constants, register codes and types for the gray-coded mpsk symbol mapper
package gmpsk_pkg;

    // symbol and sample geometry
    localparam int SYM_BITS   = 9;
    localparam int SAMPLE_W   = 16;
    localparam int MB_W       = 4;
    localparam int QUARTER    = 128;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOD_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_ORDER = 2'd1;

    typedef logic [SYM_BITS-1:0]        phase_t;
    typedef logic [MB_W-1:0]            mbits_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // one queued symbol: its phase on the circle of 2^SYM_BITS steps
    typedef struct packed {
        logic   valid;
        phase_t phase;
    } gmpsk_word_t;

endpackage

/* rtl/gray_mpsk_symbol_mapper_top.sv */
// top level of the gray-coded mpsk symbol mapper
//
// channel   direction  handshake              word
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
// s         in         s_valid / s_ready      s_bit_value
// m         out        m_valid / m_ready      m_in_phase, m_quadrature
//
// one bit word taken per clock while s_ready is high; a symbol is produced every mod_bits words
// a symbol passes the queue slot, written at the edge that takes its last bit, and then
// the lookup output register, loaded once that register is empty or being taken
// s_ready drops only for a symbol-completing bit while the queue is full
// cfg is always ready; reset is synchronous active-low, no clearing pass
module gray_mpsk_symbol_mapper_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gmpsk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmpsk_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_bit_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output gmpsk_pkg::sample_t                   m_in_phase,
    output gmpsk_pkg::sample_t                   m_quadrature
);
    import gmpsk_pkg::*;

    gmpsk_word_t push;
    gmpsk_word_t head;
    logic        q_full;
    logic        pop;

    // bit gathering and gray decode
    gmpsk_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_bit_value (s_bit_value),
        .q_full      (q_full),
        .push        (push)
    );

    // decoupling queue
    gmpsk_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (q_full)
    );

    // symbol lookup and output
    gmpsk_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_in_phase   (m_in_phase),
        .m_quadrature (m_quadrature)
    );

endmodule

/* rtl/gmpsk_front.sv */
// front end: config registers, bit gathering, gray decode and phase computation
module gmpsk_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gmpsk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmpsk_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_bit_value,
    input  logic                                 q_full,
    output gmpsk_pkg::gmpsk_word_t               push
);
    import gmpsk_pkg::*;

    mbits_t mod_bits_reg, mod_bits_next;
    logic   bit_order_reg, bit_order_next;
    phase_t gathered_reg, gathered_next;
    mbits_t held_reg, held_next;

    mbits_t mb_eff;
    mbits_t held_inc;
    mbits_t shamt;
    logic   will_complete;
    logic   accept;
    phase_t bits_in;
    phase_t code_mask;
    phase_t gray_code;
    phase_t index_k;

    // config port never stalls
    assign cfg_ready = 1'b1;

    always_comb begin
        mod_bits_next  = mod_bits_reg;
        bit_order_next = bit_order_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MOD_BITS:  mod_bits_next  = cfg_data;
                REG_BIT_ORDER: bit_order_next = cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // effective bits per symbol, zero acts as one and large values clamp
    always_comb begin
        priority if (mod_bits_reg == '0)
            mb_eff = mbits_t'(1);
        else if (mod_bits_reg > mbits_t'(SYM_BITS))
            mb_eff = mbits_t'(SYM_BITS);
        else
            mb_eff = mod_bits_reg;
    end

    assign held_inc      = held_reg + mbits_t'(1);
    assign will_complete = (held_inc >= mb_eff);
    assign s_ready       = !(will_complete && q_full);
    assign accept        = s_valid && s_ready;

    // new word placed at the bottom (msb first) or at its own slot (lsb first)
    always_comb begin
        for (int i = 0; i < SYM_BITS; i++) begin
            bits_in[i]   = s_bit_value && (held_reg == mbits_t'(i));
            code_mask[i] = (mbits_t'(i) < mb_eff);
        end
    end

    always_comb begin
        if (bit_order_reg)
            gathered_next = {gathered_reg[SYM_BITS-2:0], s_bit_value};
        else
            gathered_next = gathered_reg | bits_in;
    end

    // gray to binary: each bit is the xor of itself and all higher bits
    assign gray_code = gathered_next & code_mask;
    always_comb begin
        index_k[SYM_BITS-1] = gray_code[SYM_BITS-1];
        for (int i = SYM_BITS - 2; i >= 0; i--) begin
            index_k[i] = index_k[i+1] ^ gray_code[i];
        end
    end

    // scale index up to the full phase circle
    assign shamt      = mbits_t'(SYM_BITS) - mb_eff;
    assign push.valid = accept && will_complete;
    assign push.phase = phase_t'(index_k << shamt);

    assign held_next = will_complete ? '0 : held_inc;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_bits_reg  <= mbits_t'(2);
            bit_order_reg <= 1'b1;
            gathered_reg  <= '0;
            held_reg      <= '0;
        end else begin
            mod_bits_reg  <= mod_bits_next;
            bit_order_reg <= bit_order_next;
            if (accept) begin
                gathered_reg <= will_complete ? '0 : gathered_next;
                held_reg     <= held_next;
            end
        end
    end

    a_held_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg < mbits_t'(SYM_BITS))
        else $error("bit count past symbol size");

    a_clear_after_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |=> (held_reg == '0) && (gathered_reg == '0))
        else $error("gather state not cleared after symbol");

endmodule

/* rtl/gmpsk_queue.sv */
// two-word queue between the front end and the symbol lookup
module gmpsk_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gmpsk_pkg::gmpsk_word_t  push,
    input  logic                    pop,
    output gmpsk_pkg::gmpsk_word_t  head,
    output logic                    full
);
    import gmpsk_pkg::*;

    phase_t     slot_reg [0:1];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head.valid = (count_reg != 2'd0);
    assign head.phase = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push.valid) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

/* rtl/gmpsk_back.sv */
// back end: cosine/sine lookup and output register
module gmpsk_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gmpsk_pkg::gmpsk_word_t  head,
    output logic                    pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output gmpsk_pkg::sample_t      m_in_phase,
    output gmpsk_pkg::sample_t      m_quadrature
);
    import gmpsk_pkg::*;

    localparam int  QIDX_W   = $clog2(QUARTER + 1);
    localparam real STEP_RAD = 3.14159265358979323846 / real'(2 * QUARTER);

    typedef logic [SAMPLE_W-2:0] qsin_tab_t [0:QUARTER];

    // quarter-wave sine magnitudes, rounded to nearest, built at elaboration
    function automatic qsin_tab_t qsin_build();
        qsin_tab_t tab;
        real       amp;
        real       r;
        amp = real'((1 << (SAMPLE_W - 1)) - 1);
        for (int j = 0; j <= QUARTER; j++) begin
            r = amp * $sin(STEP_RAD * real'(j));
            tab[j] = (SAMPLE_W-1)'($rtoi(r + 0.5));
        end
        return tab;
    endfunction

    localparam qsin_tab_t QSIN = qsin_build();
    localparam phase_t    QTR  = phase_t'(QUARTER);
    localparam phase_t    HALF = phase_t'(2 * QUARTER);
    localparam phase_t    TQTR = phase_t'(3 * QUARTER);

    // signed sine on the full circle from the quarter table by symmetry
    function automatic sample_t rom_sine(input phase_t q);
        logic [QIDX_W-1:0] j;
        logic              neg;
        sample_t           mag;
        neg = 1'b0;
        priority if (q <= QTR) begin
            j = QIDX_W'(q);
        end else if (q <= HALF) begin
            j = QIDX_W'(HALF - q);
        end else if (q <= TQTR) begin
            j = QIDX_W'(q - HALF);
            neg = 1'b1;
        end else begin
            j = QIDX_W'(phase_t'(0) - q);
            neg = 1'b1;
        end
        mag = sample_t'({1'b0, QSIN[j]});
        return neg ? -mag : mag;
    endfunction

    logic    m_valid_reg, m_valid_next;
    sample_t m_in_phase_reg;
    sample_t m_quadrature_reg;
    phase_t  cos_phase;

    assign pop          = head.valid && (!m_valid_reg || m_ready);
    assign cos_phase    = head.phase + QTR;
    assign m_valid_next = pop || (m_valid_reg && !m_ready);

    // output register, refilled from the queue head whenever it is empty or being taken
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_in_phase_reg   <= rom_sine(cos_phase);
            m_quadrature_reg <= rom_sine(head.phase);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_in_phase   = m_in_phase_reg;
    assign m_quadrature = m_quadrature_reg;

    a_pop_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid_reg)
        else $error("popped symbol not presented");

endmodule

/* bench/tb_gray_mpsk_symbol_mapper_top.sv */
// self-checking bench for the gray-coded mpsk symbol mapper top level
`timescale 1ns / 1ps

module tb_gray_mpsk_symbol_mapper_top;

    import gmpsk_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_BITS      = 1380;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 16;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int LONG_HOLD_EVERY  = 120;
    localparam int CYCLE_LIMIT      = 300000;

    // sine table geometry: 2^14 steps on the circle, table entries every 2^5 steps
    localparam int unsigned QUARTER_STEPS = 4096;
    localparam int unsigned CIRCLE_MASK   = 16383;
    localparam int          ROM_SHIFT     = 5;
    localparam logic [63:0] PI_Q62        = 64'hC90FDAA22168C235;
    localparam logic [63:0] AMPLITUDE     = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic {ENTRY_BIT, ENTRY_WRITE} word_kind_e;

    typedef struct packed {
        word_kind_e            kind;
        logic                  bit_value;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
    } pending_word_t;

    typedef struct packed {
        sample_t in_phase;
        sample_t quadrature;
    } symbol_t;

    // block ports
    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_bit_value  = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    sample_t               m_in_phase;
    sample_t               m_quadrature;

    // symbol tables and mapper state mirrored by the bench
    sample_t       cos_rom [0:(1<<SYM_BITS)-1];
    sample_t       sin_rom [0:(1<<SYM_BITS)-1];
    mbits_t        set_mod_bits  = 4'd2;
    logic          set_msb_first = 1'b1;
    phase_t        gray_acc      = '0;
    mbits_t        acc_count     = '0;

    pending_word_t pending_words [$];
    symbol_t       awaited_symbols [$];

    // handshake flags sampled at the rising edge, used at the falling edge
    logic          live         = 1'b0;
    logic          bit_taken    = 1'b0;
    logic          cfg_taken    = 1'b0;
    logic          result_taken = 1'b0;
    int            quiet_edges  = 0;

    pending_word_t word_now;
    logic          word_loaded = 1'b0;
    int            gap_left    = 0;
    int            send_calm   = 0;
    int            recv_calm   = 0;
    int            hold_left   = 0;
    int            acks        = 0;

    int            fail_count      = 0;
    int            bits_mapped     = 0;
    int            symbols_checked = 0;
    int            writes_done     = 0;
    int            cycle_count     = 0;
    logic [9:0]    widths_seen     = '0;
    logic [1:0]    orders_seen     = '0;

    gray_mpsk_symbol_mapper_top i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_bit_value  (s_bit_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_in_phase   (m_in_phase),
        .m_quadrature (m_quadrature)
    );

    always #CLK_HALF aclk = ~aclk;

    // floor(a * b / 2^62) on unsigned q62 values
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // rounded amplitude * sin(2*pi*p / 2^14), exact integer taylor series in q62
    function automatic int circle_sine(input int unsigned p);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [63:0]  mag;
        logic [127:0] prod;
        int unsigned  j;
        int unsigned  n;
        logic         neg;
        p   = p & CIRCLE_MASK;
        neg = 1'b0;
        if (p <= QUARTER_STEPS) begin
            j = p;
        end else if (p <= 2 * QUARTER_STEPS) begin
            j = 2 * QUARTER_STEPS - p;
        end else if (p <= 3 * QUARTER_STEPS) begin
            j   = p - 2 * QUARTER_STEPS;
            neg = 1'b1;
        end else begin
            j   = 4 * QUARTER_STEPS - p;
            neg = 1'b1;
        end
        x    = (PI_Q62 >> 13) * 64'(j) + (((PI_Q62 & 64'd8191) * 64'(j)) >> 13);
        x2   = q62_mul(x, x);
        term = x;
        sum  = x;
        for (n = 1; n <= 30; n++) begin
            term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        prod = {64'd0, sum} * {64'd0, AMPLITUDE};
        mag  = prod[125:62] + 64'(prod[61]);
        return neg ? -int'(mag) : int'(mag);
    endfunction

    // zero for every draw inside a calm stretch, otherwise a draw from 0 to 11
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(16, 64);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // gather one bit and queue the symbol it completes, if any
    task automatic map_bit(input logic b);
        int unsigned width_now;
        phase_t      code;
        symbol_t     sym;
        if (set_mod_bits == 4'd0) begin
            width_now = 1;
        end else if (set_mod_bits > SYM_BITS) begin
            width_now = SYM_BITS;
        end else begin
            width_now = set_mod_bits;
        end
        if (set_msb_first) begin
            gray_acc = {gray_acc[SYM_BITS-2:0], b};
        end else if (acc_count < SYM_BITS) begin
            gray_acc = gray_acc | (phase_t'(b) << acc_count);
        end
        acc_count = acc_count + 1'b1;
        if (acc_count >= width_now) begin
            // gray to binary, then spread the index over the full table
            code = gray_acc & phase_t'((1 << width_now) - 1);
            code = code ^ (code >> 1);
            code = code ^ (code >> 2);
            code = code ^ (code >> 4);
            code = code ^ (code >> 8);
            code = phase_t'(code << (SYM_BITS - width_now));
            sym.in_phase   = cos_rom[code];
            sym.quadrature = sin_rom[code];
            awaited_symbols.push_back(sym);
            widths_seen[width_now]     = 1'b1;
            orders_seen[set_msb_first] = 1'b1;
            gray_acc  = '0;
            acc_count = '0;
        end
    endtask

    task automatic queue_bit(input logic b);
        pending_word_t w;
        w.kind      = ENTRY_BIT;
        w.bit_value = b;
        w.reg_index = '0;
        w.reg_data  = '0;
        pending_words.push_back(w);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        pending_word_t w;
        w.kind      = ENTRY_WRITE;
        w.bit_value = 1'b0;
        w.reg_index = idx;
        w.reg_data  = data;
        pending_words.push_back(w);
    endtask

    // monitor: register writes, accepted bits and returned symbols
    always @(posedge aclk) begin
        symbol_t due;
        live         = aresetn;
        bit_taken    = 1'b0;
        cfg_taken    = 1'b0;
        result_taken = 1'b0;
        if (!aresetn) begin
            set_mod_bits  = 4'd2;
            set_msb_first = 1'b1;
            gray_acc      = '0;
            acc_count     = '0;
            quiet_edges   = 0;
        end else begin
            bit_taken    = s_valid && (s_ready === 1'b1);
            cfg_taken    = cfg_valid && (cfg_ready === 1'b1);
            result_taken = (m_valid === 1'b1) && m_ready;
            if (result_taken) begin
                symbols_checked++;
                if (awaited_symbols.size() == 0) begin
                    $error("symbol with none awaited: in_phase %0d quadrature %0d",
                           m_in_phase, m_quadrature);
                    fail_count++;
                end else begin
                    due = awaited_symbols.pop_front();
                    if (m_in_phase !== due.in_phase) begin
                        $error("in_phase mismatch: expected %0d, got %0d",
                               due.in_phase, m_in_phase);
                        fail_count++;
                    end
                    if (m_quadrature !== due.quadrature) begin
                        $error("quadrature mismatch: expected %0d, got %0d",
                               due.quadrature, m_quadrature);
                        fail_count++;
                    end
                end
            end
            if (cfg_taken) begin
                writes_done++;
                if (cfg_index == REG_MOD_BITS) begin
                    set_mod_bits = cfg_data;
                end else if (cfg_index == REG_BIT_ORDER) begin
                    set_msb_first = cfg_data[0];
                end
            end
            if (bit_taken) begin
                bits_mapped++;
                map_bit(s_bit_value);
                quiet_edges = 0;
            end else if (quiet_edges < SETTLE_CYCLES) begin
                quiet_edges++;
            end
        end
    end

    // driver: bit words with random gaps, register writes only once drained
    always @(negedge aclk) begin
        logic next_valid;
        logic next_write;
        if (live) begin
            next_valid = s_valid && !bit_taken;
            next_write = cfg_valid && !cfg_taken;
            if (!next_valid && !next_write) begin
                if (!word_loaded && pending_words.size() != 0) begin
                    word_now    = pending_words.pop_front();
                    word_loaded = 1'b1;
                    gap_left    = (word_now.kind == ENTRY_BIT) ? draw_wait(send_calm) : 0;
                end
                if (word_loaded) begin
                    if (word_now.kind == ENTRY_BIT) begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            next_valid  = 1'b1;
                            s_bit_value <= word_now.bit_value;
                            word_loaded = 1'b0;
                        end
                    end else if (awaited_symbols.size() == 0 && quiet_edges >= SETTLE_CYCLES) begin
                        next_write  = 1'b1;
                        cfg_index   <= word_now.reg_index;
                        cfg_data    <= word_now.reg_data;
                        word_loaded = 1'b0;
                    end
                end
            end
            s_valid   <= next_valid;
            cfg_valid <= next_write;
        end
    end

    // receiver: random hold after each symbol, now and then a long one
    always @(negedge aclk) begin
        if (live) begin
            if (result_taken) begin
                acks++;
                hold_left = draw_wait(recv_calm);
                if (acks % LONG_HOLD_EVERY == 3) begin
                    hold_left = LONG_HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int          k;
        int          bits_queued;
        int          run_len;
        logic [3:0]  width_pick;
        logic [7:0]  bpsk_pattern;

        // cosine and sine tables over the 512 symbol phases
        for (k = 0; k < (1 << SYM_BITS); k++) begin
            cos_rom[k] = sample_t'(circle_sine((k << ROM_SHIFT) + QUARTER_STEPS));
            sin_rom[k] = sample_t'(circle_sine(k << ROM_SHIFT));
        end

        // qpsk, msb first as after reset
        queue_bit(1'b1);
        queue_bit(1'b1);
        queue_bit(1'b0);
        queue_bit(1'b1);

        // bpsk, the receiver holds off here so the block backs up
        queue_write(REG_MOD_BITS, 4'd1);
        bpsk_pattern = 8'b1011_0010;
        for (k = 0; k < 8; k++) begin
            queue_bit(bpsk_pattern[k]);
        end

        // 512-psk all ones, then three bits of a symbol left open
        queue_write(REG_MOD_BITS, 4'd9);
        for (k = 0; k < 9; k++) begin
            queue_bit(1'b1);
        end
        queue_bit(1'b0);
        queue_bit(1'b1);
        queue_bit(1'b1);

        // width lowered below the bits held, order flipped to lsb first
        queue_write(REG_MOD_BITS, 4'd2);
        queue_write(REG_BIT_ORDER, 4'd0);
        queue_bit(1'b0);

        // zero width acts as one bit; undecoded indexes leave state alone
        queue_write(REG_MOD_BITS, 4'd0);
        queue_write(REG_SPARE_A, 4'hF);
        queue_write(REG_SPARE_B, 4'hA);
        queue_bit(1'b1);

        // random settings, each followed by a run of random bits
        bits_queued = 0;
        while (bits_queued < RANDOM_BITS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       width_pick = 4'd0;
                    1:       width_pick = 4'd1;
                    2:       width_pick = 4'd9;
                    default: width_pick = 4'd15;
                endcase
            end else begin
                width_pick = 4'($urandom_range(0, 15));
            end
            if ($urandom_range(0, 1) == 0) begin
                queue_write(REG_BIT_ORDER, 4'($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 3) != 0) begin
                queue_write(REG_MOD_BITS, width_pick);
            end
            if ($urandom_range(0, 15) == 0) begin
                queue_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                            4'($urandom_range(0, 15)));
            end
            run_len = $urandom_range(4, 48);
            for (k = 0; k < run_len; k++) begin
                queue_bit(1'($urandom_range(0, 1)));
            end
            bits_queued += run_len;
        end

        // reset, then run
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || word_loaded || s_valid || cfg_valid) begin
            @(posedge aclk);
        end
        while (awaited_symbols.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("mapped %0d bits into %0d checked symbols across %0d register writes",
                 bits_mapped, symbols_checked, writes_done);
        $display("symbol widths hit (bit n set for n bits per symbol) %b, bit orders %b",
                 widths_seen, orders_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
